// ----- hw/rtl/hht_pkg.sv -----
// types, codes and the byte classifier for the http header tokenizer
// standalone package, no dependencies
package hht_pkg;

  // parse modes; final modes sit from mode_done upwards
  typedef enum logic [3:0] {
    MODE_START   = 4'd0,
    MODE_STATUS  = 4'd1,
    MODE_FIRSTNL = 4'd2,
    MODE_NAME    = 4'd3,
    MODE_SPACE   = 4'd4,
    MODE_VALUE   = 4'd5,
    MODE_NEWLINE = 4'd6,
    MODE_FOLD    = 4'd7,
    MODE_DONE    = 4'd8,
    MODE_NORESP  = 4'd9,
    MODE_TRUNC   = 4'd10,
    MODE_ABORT   = 4'd11
  } mode_t;

  // byte classes
  typedef enum logic [2:0] {
    CLS_ALPHA = 3'd0,
    CLS_BLANK = 3'd1,
    CLS_DIGIT = 3'd2,
    CLS_DASH  = 3'd3,
    CLS_COLON = 3'd4,
    CLS_CR    = 3'd5,
    CLS_LF    = 3'd6,
    CLS_OTHER = 3'd7
  } class_t;

  // parse error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_SPACE = 2'd1;
  localparam logic [1:0] ERR_LINE_END = 2'd2;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd3;

  // status codes
  localparam logic [2:0] STAT_PARSING   = 3'd0;
  localparam logic [2:0] STAT_COMPLETE  = 3'd1;
  localparam logic [2:0] STAT_NO_RESP   = 3'd2;
  localparam logic [2:0] STAT_TRUNCATED = 3'd3;
  localparam logic [2:0] STAT_ABORTED   = 3'd4;

  // character constants
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  // sort one byte into its class; nul falls to other
  function automatic class_t classify(input logic [7:0] b);
    class_t c;
    if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) c = CLS_ALPHA;
    else if (b == CH_SPACE || b == CH_TAB) c = CLS_BLANK;
    else if (b >= 8'h30 && b <= 8'h39) c = CLS_DIGIT;
    else if (b == CH_DASH) c = CLS_DASH;
    else if (b == CH_COLON) c = CLS_COLON;
    else if (b == CH_CR) c = CLS_CR;
    else if (b == CH_LF) c = CLS_LF;
    else c = CLS_OTHER;
    return c;
  endfunction

  // status reported for a mode
  function automatic logic [2:0] final_status(input mode_t m);
    logic [2:0] s;
    unique case (m)
      MODE_DONE:   s = STAT_COMPLETE;
      MODE_NORESP: s = STAT_NO_RESP;
      MODE_TRUNC:  s = STAT_TRUNCATED;
      MODE_ABORT:  s = STAT_ABORTED;
      default:     s = STAT_PARSING;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/http_header_tokenizer.sv -----
// Tokenizer for the head of an HTTP response. Each input word carries one
// byte (or an end-of-data mark); each accepted word gives exactly one result
// word tagging the byte as header-name or header-value text, marking the start
// of a header, and reporting parse errors and the overall status. Throughput
// is one word per cycle unless out_ready holds back the result register: the
// only feedback path is the 4-bit parse mode, updated in the same cycle the
// word is accepted. The result is registered as the word is accepted; a new
// word is taken while that result waits if it is being taken in the same cycle.
// depends on hht_pkg
module http_header_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_data,
  input  logic       user_abort,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       name_char_valid,
  output logic       value_char_valid,
  output logic [7:0] out_char,
  output logic       header_start,
  output logic [1:0] parse_error,
  output logic [2:0] status
);
  import hht_pkg::*;

  mode_t      tok_mode;
  mode_t      tok_mode_next;
  class_t     cls;
  logic       nv;
  logic       vv;
  logic [7:0] ch;
  logic       hs;
  logic [1:0] err;
  logic       in_take;

  // accept when the result register is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;
  assign cls      = classify(in_byte);

  // mode decision and result for the current word
  always_comb begin
    tok_mode_next = tok_mode;
    nv  = 1'b0;
    vv  = 1'b0;
    ch  = 8'h00;
    hs  = 1'b0;
    err = ERR_NONE;
    if (tok_mode >= MODE_DONE) begin
      // final modes hold until reset
      tok_mode_next = tok_mode;
    end else if (end_of_data) begin
      if (user_abort) tok_mode_next = MODE_ABORT;
      else if (tok_mode == MODE_START) tok_mode_next = MODE_NORESP;
      else tok_mode_next = MODE_TRUNC;
    end else begin
      unique case (tok_mode)
        MODE_START: begin
          if (cls == CLS_ALPHA) tok_mode_next = MODE_STATUS;
          else err = ERR_BAD_CHAR;
        end
        MODE_STATUS: begin
          // reason phrase skipped up to the line feed
          if (cls == CLS_LF) tok_mode_next = MODE_FIRSTNL;
        end
        MODE_FIRSTNL, MODE_NEWLINE: begin
          if (cls == CLS_ALPHA) begin
            hs = 1'b1;
            nv = 1'b1;
            ch = in_byte;
            tok_mode_next = MODE_NAME;
          end else if (cls == CLS_CR) begin
            tok_mode_next = tok_mode;
          end else if (cls == CLS_LF) begin
            tok_mode_next = MODE_DONE;
          end else if (cls == CLS_BLANK && tok_mode == MODE_NEWLINE) begin
            // continuation line folds into one space
            vv = 1'b1;
            ch = CH_SPACE;
            tok_mode_next = MODE_FOLD;
          end else begin
            err = ERR_BAD_CHAR;
          end
        end
        MODE_NAME: begin
          if (cls == CLS_ALPHA || cls == CLS_DIGIT || cls == CLS_DASH) begin
            nv = 1'b1;
            ch = in_byte;
          end else if (cls == CLS_COLON) begin
            tok_mode_next = MODE_SPACE;
          end else if (cls == CLS_LF) begin
            err = ERR_LINE_END;
            tok_mode_next = MODE_NEWLINE;
          end else begin
            err = ERR_BAD_CHAR;
          end
        end
        MODE_SPACE: begin
          if (cls == CLS_BLANK) begin
            tok_mode_next = MODE_VALUE;
          end else if (cls == CLS_LF) begin
            err = ERR_LINE_END;
            tok_mode_next = MODE_NEWLINE;
          end else if (cls == CLS_CR) begin
            err = ERR_BAD_CHAR;
          end else begin
            err = ERR_NO_SPACE;
            vv  = 1'b1;
            ch  = in_byte;
            tok_mode_next = MODE_VALUE;
          end
        end
        MODE_VALUE: begin
          if (cls == CLS_LF) begin
            tok_mode_next = MODE_NEWLINE;
          end else if (cls != CLS_CR) begin
            vv = 1'b1;
            ch = in_byte;
          end
        end
        MODE_FOLD: begin
          if (cls == CLS_BLANK) begin
            tok_mode_next = tok_mode;
          end else if (cls == CLS_LF) begin
            err = ERR_LINE_END;
            tok_mode_next = MODE_NEWLINE;
          end else if (cls == CLS_CR) begin
            err = ERR_BAD_CHAR;
          end else begin
            vv = 1'b1;
            ch = in_byte;
            tok_mode_next = MODE_VALUE;
          end
        end
        default: begin
          tok_mode_next = tok_mode;
        end
      endcase
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_mode <= MODE_START;
    end else if (in_take) begin
      tok_mode <= tok_mode_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (in_take) begin
      name_char_valid  <= nv;
      value_char_valid <= vv;
      out_char         <= ch;
      header_start     <= hs;
      parse_error      <= err;
      status           <= final_status(tok_mode_next);
    end
  end

endmodule

// ----- test/tb_http_header_tokenizer.sv -----
// self-checking testbench for the http header tokenizer: streams a response head one
// byte word at a time and checks every result word against a built-in predictor
// depends on hht_pkg and http_header_tokenizer
module tb_http_header_tokenizer;
  import hht_pkg::*;

  localparam int WORD_TARGET = 950;
  localparam int CYCLE_LIMIT = 200000;

  // one result word as the block reports it
  typedef struct packed {
    logic       nv;
    logic       vv;
    logic [7:0] ch;
    logic       hs;
    logic [1:0] err;
    logic [2:0] st;
  } tok_result_t;

  // tracks the parse mode and holds the results still owed by the block
  class token_scoreboard;
    mode_t       mode;
    tok_result_t owed[$];
    int          errors;

    function new();
      mode = MODE_START;
      errors = 0;
    endfunction

    function class_t class_of(logic [7:0] b);
      if (b inside {[8'h41:8'h5a], [8'h61:8'h7a]}) return CLS_ALPHA;
      if (b == 8'h20 || b == 8'h09) return CLS_BLANK;
      if (b inside {[8'h30:8'h39]}) return CLS_DIGIT;
      if (b == 8'h2d) return CLS_DASH;
      if (b == 8'h3a) return CLS_COLON;
      if (b == 8'h0d) return CLS_CR;
      if (b == 8'h0a) return CLS_LF;
      return CLS_OTHER;
    endfunction

    function logic [2:0] status_of(mode_t m);
      case (m)
        MODE_DONE:   return STAT_COMPLETE;
        MODE_NORESP: return STAT_NO_RESP;
        MODE_TRUNC:  return STAT_TRUNCATED;
        MODE_ABORT:  return STAT_ABORTED;
        default:     return STAT_PARSING;
      endcase
    endfunction

    // advance the mode for an accepted word and queue the result it owes
    function void note_word(logic [7:0] b, logic eod, logic abort_req);
      tok_result_t r;
      class_t      c;
      r = '0;
      c = class_of(b);
      if (mode >= MODE_DONE) begin
        // final modes hold until reset
      end else if (eod) begin
        if (abort_req) mode = MODE_ABORT;
        else if (mode == MODE_START) mode = MODE_NORESP;
        else mode = MODE_TRUNC;
      end else begin
        case (mode)
          MODE_START: begin
            if (c == CLS_ALPHA) mode = MODE_STATUS;
            else r.err = ERR_BAD_CHAR;
          end
          MODE_STATUS: begin
            if (c == CLS_LF) mode = MODE_FIRSTNL;
          end
          MODE_FIRSTNL, MODE_NEWLINE: begin
            if (c == CLS_ALPHA) begin
              r.hs = 1'b1;
              r.nv = 1'b1;
              r.ch = b;
              mode = MODE_NAME;
            end else if (c == CLS_LF) begin
              mode = MODE_DONE;
            end else if (c == CLS_BLANK && mode == MODE_NEWLINE) begin
              r.vv = 1'b1;
              r.ch = CH_SPACE;
              mode = MODE_FOLD;
            end else if (c != CLS_CR) begin
              r.err = ERR_BAD_CHAR;
            end
          end
          MODE_NAME: begin
            if (c == CLS_ALPHA || c == CLS_DIGIT || c == CLS_DASH) begin
              r.nv = 1'b1;
              r.ch = b;
            end else if (c == CLS_COLON) begin
              mode = MODE_SPACE;
            end else if (c == CLS_LF) begin
              r.err = ERR_LINE_END;
              mode = MODE_NEWLINE;
            end else begin
              r.err = ERR_BAD_CHAR;
            end
          end
          MODE_SPACE: begin
            if (c == CLS_BLANK) begin
              mode = MODE_VALUE;
            end else if (c == CLS_LF) begin
              r.err = ERR_LINE_END;
              mode = MODE_NEWLINE;
            end else if (c == CLS_CR) begin
              r.err = ERR_BAD_CHAR;
            end else begin
              r.err = ERR_NO_SPACE;
              r.vv = 1'b1;
              r.ch = b;
              mode = MODE_VALUE;
            end
          end
          MODE_VALUE: begin
            if (c == CLS_LF) begin
              mode = MODE_NEWLINE;
            end else if (c != CLS_CR) begin
              r.vv = 1'b1;
              r.ch = b;
            end
          end
          MODE_FOLD: begin
            // further blanks of a fold are dropped
            if (c == CLS_LF) begin
              r.err = ERR_LINE_END;
              mode = MODE_NEWLINE;
            end else if (c == CLS_CR) begin
              r.err = ERR_BAD_CHAR;
            end else if (c != CLS_BLANK) begin
              r.vv = 1'b1;
              r.ch = b;
              mode = MODE_VALUE;
            end
          end
          default: ;
        endcase
      end
      r.st = status_of(mode);
      owed.push_back(r);
    endfunction

    // compare one result word with the oldest one owed
    function void check_result(tok_result_t got);
      tok_result_t want;
      if (owed.size() == 0) begin
        $error("result word with nothing owed");
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.nv !== want.nv) begin
        $error("name_char_valid expected %0d got %0d", want.nv, got.nv);
        errors++;
      end
      if (got.vv !== want.vv) begin
        $error("value_char_valid expected %0d got %0d", want.vv, got.vv);
        errors++;
      end
      if (got.ch !== want.ch) begin
        $error("out_char expected %02h got %02h", want.ch, got.ch);
        errors++;
      end
      if (got.hs !== want.hs) begin
        $error("header_start expected %0d got %0d", want.hs, got.hs);
        errors++;
      end
      if (got.err !== want.err) begin
        $error("parse_error expected %0d got %0d", want.err, got.err);
        errors++;
      end
      if (got.st !== want.st) begin
        $error("status expected %0d got %0d", want.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_data = 1'b0;
  logic       user_abort = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       name_char_valid;
  logic       value_char_valid;
  logic [7:0] out_char;
  logic       header_start;
  logic [1:0] parse_error;
  logic [2:0] status;

  token_scoreboard sb = new();
  int send_idle = 34;
  int recv_idle = 45;
  int words_sent = 0;
  int cycles = 0;
  bit closing = 1'b0;

  http_header_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .end_of_data(end_of_data),
    .user_abort(user_abort),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .name_char_valid(name_char_valid),
    .value_char_valid(value_char_valid),
    .out_char(out_char),
    .header_start(header_start),
    .parse_error(parse_error),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // take result words
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result('{name_char_valid, value_char_valid, out_char, header_start,
                        parse_error, status});
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // present one word, hold it until taken, then book its result
  task automatic send_word(input logic [7:0] b, input logic eod = 1'b0,
                           input logic abort_req = $urandom_range(1));
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    // a bare line end here would close the head too early
    if (!closing && !eod && b == CH_LF &&
        (sb.mode == MODE_NEWLINE || sb.mode == MODE_FIRSTNL)) begin
      b = 8'h78;
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_data <= eod;
    user_abort <= abort_req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.mode < MODE_DONE) words_sent++;
    sb.note_word(b, eod, abort_req);
  endtask

  function automatic logic [7:0] any_letter();
    if ($urandom_range(1)) return 8'($urandom_range(8'h41, 8'h5a));
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic logic [7:0] name_byte();
    case ($urandom_range(5))
      0:       return 8'($urandom_range(8'h30, 8'h39));
      1:       return CH_DASH;
      default: return any_letter();
    endcase
  endfunction

  // any byte that does not end a line
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return $urandom_range(1) ? CH_TAB : CH_SPACE;
  endfunction

  // line end, mostly with cr
  task automatic send_line_end();
    if ($urandom_range(9) != 0) send_word(CH_CR);
    send_word(CH_LF);
  endtask

  // one header line with random content, sometimes folded or malformed
  task automatic send_header();
    int n;
    int pick;
    send_word(any_letter());
    n = $urandom_range(7);
    repeat (n) send_word(name_byte());
    send_word(CH_COLON);
    pick = $urandom_range(99);
    if (pick < 80) send_word(blank_byte());
    else if (pick < 88) send_word(text_byte());
    else if (pick < 94) send_word(CH_CR);
    else send_word(CH_LF);
    n = $urandom_range(12);
    repeat (n) send_word(text_byte());
    send_line_end();
    // continuation lines
    while ($urandom_range(4) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_word(blank_byte());
      pick = $urandom_range(9);
      if (pick == 0) send_word(CH_CR);
      if (pick == 1) begin
        send_word(CH_LF);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_word(text_byte());
        send_line_end();
      end
    end
  endtask

  initial begin
    logic [7:0] opening[$];
    int pick;
    opening = '{8'h00, 8'h31, 8'h48, CH_DASH, CH_COLON, 8'hff, CH_LF,
                CH_SPACE, CH_CR, 8'h41, 8'h39, CH_DASH, CH_SPACE, CH_LF,
                8'h42, CH_COLON, CH_LF,
                8'h63, CH_COLON, CH_CR, 8'h80, 8'h00, CH_LF,
                CH_TAB, CH_SPACE, CH_CR, 8'h76, CH_LF,
                CH_SPACE, CH_LF, CH_COLON};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed opening: start mode errors, status line skip, every header error
    foreach (opening[i]) send_word(opening[i]);

    // random head content over three idling phases
    while (words_sent < WORD_TARGET) begin
      if (words_sent < WORD_TARGET / 3) begin
        send_idle = 34;
        recv_idle = 45;
      end else if (words_sent < 2 * WORD_TARGET / 3) begin
        send_idle = 45;
        recv_idle = 34;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if ($urandom_range(9) == 0) begin
        pick = $urandom_range(1, 3);
        repeat (pick) send_word(8'($urandom_range(255)));
      end else begin
        send_header();
      end
    end

    // close the head one of three ways, then check the final mode holds
    closing = 1'b1;
    pick = $urandom_range(2);
    if (pick == 0) begin
      while (sb.mode < MODE_DONE) send_word(CH_LF);
    end else begin
      send_word(8'($urandom_range(255)), 1'b1, logic'(pick == 2));
    end
    repeat (6) send_word(8'($urandom_range(255)), logic'($urandom_range(1)));
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- http_header_tokenizer.f -----
hw/rtl/hht_pkg.sv
hw/rtl/http_header_tokenizer.sv
test/tb_http_header_tokenizer.sv
